// ===== rtl/core/stfp_pkg.sv =====
package stfp_pkg;

  localparam int unsigned Lanes    = 4;
  localparam int unsigned RawW     = 12;
  localparam int unsigned ChanW    = 10;
  localparam int unsigned TrimW    = 16;
  localparam int unsigned XW       = 22;  // holds (4095 - raw) * 1000
  localparam int unsigned KeyW     = 4;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned SumW     = 11;  // sum of the 13 head/body bytes stays below 2048
  localparam int unsigned FrameLength = 17;
  localparam int unsigned SumSpan  = 13;
  localparam int unsigned CntW     = $clog2(FrameLength);

  localparam logic [RawW-1:0]         AdcFull  = 12'd4095;
  localparam logic [ChanW-1:0]        ScaleTop = 10'd1000;
  localparam logic signed [TrimW-1:0] MidPoint = 16'sd500;
  localparam logic signed [TrimW:0]   TrimStep = 17'sd10;

  // channel lanes
  localparam int unsigned ChThr   = 0;
  localparam int unsigned ChPitch = 1;
  localparam int unsigned ChRoll  = 2;
  localparam int unsigned ChYaw   = 3;

  typedef logic [1:0] kind_t;
  localparam kind_t KindSample = 2'd0;
  localparam kind_t KindKey    = 2'd1;
  localparam kind_t KindSend   = 2'd2;
  localparam kind_t KindReport = 2'd3;

  typedef logic [KeyW-1:0] key_t;
  localparam key_t KeyUp         = 4'd1;
  localparam key_t KeyDown       = 4'd2;
  localparam key_t KeyLeft       = 4'd3;
  localparam key_t KeyRight      = 4'd4;
  localparam key_t KeyLeftx      = 4'd5;
  localparam key_t KeyRightx     = 4'd6;
  localparam key_t KeyRightxLong = 4'd8;

  typedef logic [1:0] outcome_t;
  localparam outcome_t OutMaxRetry  = 2'd0;
  localparam outcome_t OutDelivered = 2'd1;

  typedef logic [1:0] link_t;
  localparam link_t LinkOk   = 2'd0;
  localparam link_t LinkErr  = 2'd1;
  localparam link_t LinkNone = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t RegHeadOne   = 2'd0;
  localparam reg_idx_t RegHeadTwo   = 2'd1;
  localparam reg_idx_t RegHeadThree = 2'd2;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    logic sample;
    logic step_up;
    logic step_dn;
    logic recentre;
    logic mid;       // recentre to midpoint, else to zero
  } lane_ctl_t;

  typedef struct packed {
    logic  load_frame;
    logic  load_rep;
    link_t status;
  } frame_ctl_t;

endpackage

// ===== rtl/core/stfp_lane.sv =====
module stfp_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [stfp_pkg::RawW-1:0]  raw_i,
  input  stfp_pkg::lane_ctl_t        ctl_i,
  output stfp_pkg::chan_t            trimmed_o
);

  localparam int unsigned XW = stfp_pkg::XW;
  localparam int unsigned CW = stfp_pkg::ChanW;
  localparam int unsigned TW = stfp_pkg::TrimW;

  logic [stfp_pkg::RawW-1:0] inv;
  logic [XW-1:0]             x_d, x_q;
  logic [XW:0]               acc, rem;
  logic [CW-1:0]             qa_d, qa_q;
  logic                      corr_d, corr_q;
  logic [CW-1:0]             quo_q;
  logic [CW-1:0]             scaled;
  logic signed [CW+7:0]      sum_t;
  logic signed [TW:0]        step;
  logic [CW-1:0]             scaled_d, scaled_q;
  logic [CW-1:0]             trimmed_d, trimmed_q;
  logic signed [TW-1:0]      trim_d, trim_q;

  // stage 1: invert and multiply by 1000 = 1024 - 16 - 8
  assign inv = stfp_pkg::AdcFull - raw_i;
  assign x_d = XW'({inv, 10'b0}) - XW'({inv, 4'b0}) - XW'({inv, 3'b0});

  // stage 2: x / 4095 ~ (x + x/4096) / 4096, never high, at most one low
  assign acc    = {1'b0, x_q} + (XW+1)'(x_q >> 12);
  assign qa_d   = acc[CW+11:12];
  assign rem    = {1'b0, x_q} + (XW+1)'(qa_d) - (XW+1)'({qa_d, 12'b0});
  assign corr_d = rem >= (XW+1)'(stfp_pkg::AdcFull);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q    <= x_d;
      qa_q   <= qa_d;
      corr_q <= corr_d;
      quo_q  <= qa_q + CW'(corr_q);
    end
  end

  // stage 3: trim, clamp, state update
  assign scaled = quo_q;
  assign sum_t  = $signed({8'b0, scaled}) + $signed({{2{trim_q[TW-1]}}, trim_q});
  assign step   = $signed({trim_q[TW-1], trim_q})
                + (ctl_i.step_up ? stfp_pkg::TrimStep : -stfp_pkg::TrimStep);

  always_comb begin
    scaled_d  = scaled_q;
    trimmed_d = trimmed_q;
    trim_d    = trim_q;
    if (ctl_i.sample) begin
      scaled_d = scaled;
      if (sum_t < 0) begin
        trimmed_d = '0;
      end else if (sum_t > $signed({8'b0, stfp_pkg::ScaleTop})) begin
        trimmed_d = stfp_pkg::ScaleTop;
      end else begin
        trimmed_d = sum_t[CW-1:0];
      end
    end
    if (ctl_i.step_up || ctl_i.step_dn) begin
      if (step[TW] != step[TW-1]) begin
        trim_d = step[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
      end else begin
        trim_d = step[TW-1:0];
      end
    end
    if (ctl_i.recentre) begin
      trim_d = (ctl_i.mid ? stfp_pkg::MidPoint : '0) - $signed({6'b0, scaled_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scaled_q  <= '0;
      trimmed_q <= '0;
      trim_q    <= '0;
    end else begin
      scaled_q  <= scaled_d;
      trimmed_q <= trimmed_d;
      trim_q    <= trim_d;
    end
  end

  assign trimmed_o = trimmed_q;

endmodule

// ===== rtl/core/stfp_framer.sv =====
module stfp_framer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stfp_pkg::frame_ctl_t ctl_i,
  input  stfp_pkg::chan_t      chan_i [stfp_pkg::Lanes],
  input  logic                 hold_i,
  input  logic                 off_i,
  input  logic [7:0]           head_one_i,
  input  logic [7:0]           head_two_i,
  input  logic [7:0]           head_three_i,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [7:0]           m_tdata_o,
  output logic                 m_tlast_o,
  output stfp_pkg::link_t      m_tuser_o,
  output logic                 free_o
);

  localparam int unsigned CW = stfp_pkg::CntW;
  localparam int unsigned SW = stfp_pkg::SumW;
  localparam logic [CW-1:0] LastIdx = CW'(stfp_pkg::FrameLength - 1);

  logic                    valid_q;
  logic                    rep_q;
  logic [CW-1:0]           cnt_q;
  logic [SW-1:0]           sum_q;
  stfp_pkg::link_t         status_q;
  stfp_pkg::chan_t         chan_q [stfp_pkg::Lanes];
  logic                    hold_q, off_q;
  logic [7:0]              frame_byte;
  logic                    take, done_item;
  logic [31:0]             sum_w;

  assign sum_w = 32'(sum_q);

  // merge the lane snapshot into the serial byte order
  always_comb begin
    case (cnt_q)
      5'd0:    frame_byte = head_one_i;
      5'd1:    frame_byte = head_two_i;
      5'd2:    frame_byte = head_three_i;
      5'd3:    frame_byte = {6'b0, chan_q[stfp_pkg::ChThr][9:8]};
      5'd4:    frame_byte = chan_q[stfp_pkg::ChThr][7:0];
      5'd5:    frame_byte = {6'b0, chan_q[stfp_pkg::ChPitch][9:8]};
      5'd6:    frame_byte = chan_q[stfp_pkg::ChPitch][7:0];
      5'd7:    frame_byte = {6'b0, chan_q[stfp_pkg::ChRoll][9:8]};
      5'd8:    frame_byte = chan_q[stfp_pkg::ChRoll][7:0];
      5'd9:    frame_byte = {6'b0, chan_q[stfp_pkg::ChYaw][9:8]};
      5'd10:   frame_byte = chan_q[stfp_pkg::ChYaw][7:0];
      5'd11:   frame_byte = {7'b0, hold_q};
      5'd12:   frame_byte = {7'b0, off_q};
      5'd13:   frame_byte = sum_w[31:24];
      5'd14:   frame_byte = sum_w[23:16];
      5'd15:   frame_byte = sum_w[15:8];
      5'd16:   frame_byte = sum_w[7:0];
      default: frame_byte = '0;
    endcase
  end

  assign take      = valid_q && m_tready_i;
  assign done_item = rep_q || (cnt_q == LastIdx);
  assign free_o    = !valid_q || (take && done_item);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rep_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (ctl_i.load_frame) begin
      valid_q <= 1'b1;
      rep_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (ctl_i.load_rep) begin
      valid_q <= 1'b1;
      rep_q   <= 1'b1;
      cnt_q   <= '0;
    end else if (take) begin
      if (done_item) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // checksum builds up as the leading bytes go out
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_frame) begin
      sum_q  <= '0;
      chan_q <= chan_i;
      hold_q <= hold_i;
      off_q  <= off_i;
    end else if (take && !rep_q && (cnt_q < CW'(stfp_pkg::SumSpan))) begin
      sum_q <= sum_q + SW'(frame_byte);
    end
    if (ctl_i.load_rep) begin
      status_q <= ctl_i.status;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = rep_q ? 8'd0 : frame_byte;
  assign m_tlast_o  = !rep_q && (cnt_q == LastIdx);
  assign m_tuser_o  = rep_q ? status_q : stfp_pkg::LinkOk;

endmodule

// ===== rtl/core/stick_trim_frame_packer.sv =====
// Four-lane stick conditioner and frame packer.
// An item runs three pipeline stages; its first result is presented
// the cycle after it leaves the third stage.
// Throughput: one item per cycle; a send holds the output for its 17 frame bytes
// and a report for one beat, and the pipe stalls when either meets a busy output.
// Reset clears trims, channel values, flags and header registers at once.
module stick_trim_frame_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // raw_throttle, raw_pitch, raw_roll, raw_yaw, key_code, radio_outcome, pad
  input  logic [55:0] s_axis_tdata_i,
  // kind
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // frame_byte
  output logic [7:0]  m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  // link_status
  output logic [1:0]  m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned RW = stfp_pkg::RawW;

  logic                  adv, fire, free;
  logic                  v1_q, v2_q, v3_q;
  stfp_pkg::kind_t       kind1_q, kind2_q, kind3_q;
  stfp_pkg::key_t        key1_q, key2_q, key3_q;
  stfp_pkg::outcome_t    out1_q, out2_q, out3_q;
  logic                  hold_q, off_q;
  logic [7:0]            head_one_q, head_two_q, head_three_q;
  stfp_pkg::chan_t       trimmed [stfp_pkg::Lanes];
  stfp_pkg::lane_ctl_t   lane_ctl [stfp_pkg::Lanes];
  stfp_pkg::frame_ctl_t  frame_ctl;
  stfp_pkg::link_t       status;
  logic                  is_key, is_send, is_rep;

  assign is_key  = fire && (kind3_q == stfp_pkg::KindKey);
  assign is_send = fire && (kind3_q == stfp_pkg::KindSend);
  assign is_rep  = fire && (kind3_q == stfp_pkg::KindReport);

  // hold the whole pipe while a send or report waits for the output
  assign adv = !(v3_q && ((kind3_q == stfp_pkg::KindSend) ||
                          (kind3_q == stfp_pkg::KindReport)) && !free);
  assign fire = v3_q && adv;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind1_q <= s_axis_tuser_i;
      key1_q  <= s_axis_tdata_i[51:48];
      out1_q  <= s_axis_tdata_i[53:52];
      kind2_q <= kind1_q;
      key2_q  <= key1_q;
      out2_q  <= out1_q;
      kind3_q <= kind2_q;
      key3_q  <= key2_q;
      out3_q  <= out2_q;
    end
  end

  for (genvar g = 0; g < stfp_pkg::Lanes; g++) begin : g_lane
    assign lane_ctl[g].sample   = fire && (kind3_q == stfp_pkg::KindSample);
    assign lane_ctl[g].step_up  = is_key &&
        (((g == stfp_pkg::ChPitch) && (key3_q == stfp_pkg::KeyUp)) ||
         ((g == stfp_pkg::ChRoll)  && (key3_q == stfp_pkg::KeyRight)));
    assign lane_ctl[g].step_dn  = is_key &&
        (((g == stfp_pkg::ChPitch) && (key3_q == stfp_pkg::KeyDown)) ||
         ((g == stfp_pkg::ChRoll)  && (key3_q == stfp_pkg::KeyLeft)));
    assign lane_ctl[g].recentre = is_key && (key3_q == stfp_pkg::KeyRightxLong);
    assign lane_ctl[g].mid      = (g != stfp_pkg::ChThr);

    stfp_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .raw_i     (s_axis_tdata_i[g*RW +: RW]),
      .ctl_i     (lane_ctl[g]),
      .trimmed_o (trimmed[g])
    );
  end

  always_comb begin
    case (out3_q)
      stfp_pkg::OutMaxRetry:  status = stfp_pkg::LinkErr;
      stfp_pkg::OutDelivered: status = stfp_pkg::LinkOk;
      default:                status = stfp_pkg::LinkNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      off_q  <= 1'b0;
    end else begin
      if (is_key && (key3_q == stfp_pkg::KeyLeftx)) begin
        off_q <= 1'b1;
      end
      if (is_key && (key3_q == stfp_pkg::KeyRightx)) begin
        hold_q <= 1'b1;
      end
      if (is_rep && (out3_q == stfp_pkg::OutDelivered)) begin
        hold_q <= 1'b0;
        off_q  <= 1'b0;
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_one_q   <= '0;
      head_two_q   <= '0;
      head_three_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        stfp_pkg::RegHeadOne:   head_one_q   <= cfg_data_i;
        stfp_pkg::RegHeadTwo:   head_two_q   <= cfg_data_i;
        stfp_pkg::RegHeadThree: head_three_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign frame_ctl.load_frame = is_send;
  assign frame_ctl.load_rep   = is_rep;
  assign frame_ctl.status     = status;

  stfp_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (frame_ctl),
    .chan_i       (trimmed),
    .hold_i       (hold_q),
    .off_i        (off_q),
    .head_one_i   (head_one_q),
    .head_two_i   (head_two_q),
    .head_three_i (head_three_q),
    .m_tready_i   (m_axis_tready_i),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tdata_o    (m_axis_tdata_o),
    .m_tlast_o    (m_axis_tlast_o),
    .m_tuser_o    (m_axis_tuser_o),
    .free_o       (free)
  );

  // a stalled input is only ever caused by a pending output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with idle output");

  a_send_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_send |=> m_axis_tvalid_o && !m_axis_tlast_o && (m_axis_tdata_o == head_one_q))
    else $error("frame did not start with head byte");

  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == stfp_pkg::LinkOk)
    else $error("frame byte with link status");

  a_flags_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_rep && (out3_q == stfp_pkg::OutDelivered) |=> !hold_q && !off_q)
    else $error("flags not cleared on delivery");

endmodule

// ===== sim/stick_trim_frame_packer_tb.sv =====
`timescale 1ns / 1ps

module stick_trim_frame_packer_tb;

  localparam int unsigned Lanes = stfp_pkg::Lanes;
  localparam int unsigned RawW = stfp_pkg::RawW;
  localparam int unsigned ChanW = stfp_pkg::ChanW;
  localparam int unsigned FrameLength = stfp_pkg::FrameLength;
  localparam int unsigned SumSpan = stfp_pkg::SumSpan;
  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned RandomRequests = 280;
  localparam int unsigned SettleCycles = 8;

  // codes the block treats as no-ops
  localparam stfp_pkg::key_t KeyNone = 4'd0;
  localparam stfp_pkg::key_t KeyLeftxLong = 4'd7;
  localparam stfp_pkg::key_t KeyFirstSpare = 4'd9;
  localparam stfp_pkg::key_t KeyLastSpare = 4'd15;
  localparam stfp_pkg::outcome_t OutQuiet = 2'd2;
  localparam stfp_pkg::outcome_t OutQuietAlt = 2'd3;
  localparam stfp_pkg::reg_idx_t RegUnused = 2'd3;

  typedef struct packed {
    stfp_pkg::kind_t kind;
    stfp_pkg::outcome_t outcome;
    stfp_pkg::key_t key;
    logic [Lanes-1:0][RawW-1:0] raw;  // lane 0 throttle in the low bits
  } stick_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic last;
    stfp_pkg::link_t status;
  } frame_beat_t;

  typedef enum logic [1:0] {StallNone, StallCoin, StallPeriodic, StallLong} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic m_axis_tlast_o;
  logic [1:0] m_axis_tuser_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  stick_trim_frame_packer uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o,
    .m_axis_tuser_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // shadow of the block's state
  logic [7:0] head_bytes[3] = '{default: '0};
  logic [ChanW-1:0] lane_scaled[Lanes] = '{default: '0};
  logic [ChanW-1:0] lane_trimmed[Lanes] = '{default: '0};
  int lane_trim[Lanes] = '{default: 0};
  logic hold_on = 1'b0;
  logic off_on = 1'b0;

  stick_req_t stick_reqs[$];
  frame_beat_t pending_beats[$];
  stick_req_t drv_req;
  frame_beat_t got_beat;
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  stall_mode_e stall_mode = StallNone;

  function automatic void step_trim(int lane, int delta);
    int v;
    v = lane_trim[lane] + delta;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    lane_trim[lane] = v;
  endfunction

  // advance the shadow state by one request and queue the beats it causes
  function automatic void predict_beats(stick_req_t r);
    logic [7:0] fb[FrameLength];
    int t;
    int unsigned sum;
    frame_beat_t b;
    case (r.kind)
      stfp_pkg::KindSample: begin
        for (int i = 0; i < Lanes; i++) begin
          lane_scaled[i] = ChanW'(((int'(stfp_pkg::AdcFull) - int'(r.raw[i]))
                                   * int'(stfp_pkg::ScaleTop)) / int'(stfp_pkg::AdcFull));
          t = int'(lane_scaled[i]) + lane_trim[i];
          if (t > int'(stfp_pkg::ScaleTop)) t = int'(stfp_pkg::ScaleTop);
          if (t < 0) t = 0;
          lane_trimmed[i] = ChanW'(t);
        end
      end
      stfp_pkg::KindKey: begin
        case (r.key)
          stfp_pkg::KeyUp: step_trim(stfp_pkg::ChPitch, int'(stfp_pkg::TrimStep));
          stfp_pkg::KeyDown: step_trim(stfp_pkg::ChPitch, -int'(stfp_pkg::TrimStep));
          stfp_pkg::KeyLeft: step_trim(stfp_pkg::ChRoll, -int'(stfp_pkg::TrimStep));
          stfp_pkg::KeyRight: step_trim(stfp_pkg::ChRoll, int'(stfp_pkg::TrimStep));
          stfp_pkg::KeyLeftx: off_on = 1'b1;
          stfp_pkg::KeyRightx: hold_on = 1'b1;
          stfp_pkg::KeyRightxLong: begin
            // recentre works from the untrimmed values
            lane_trim[stfp_pkg::ChRoll] = int'(stfp_pkg::MidPoint)
                                        - int'(lane_scaled[stfp_pkg::ChRoll]);
            lane_trim[stfp_pkg::ChPitch] = int'(stfp_pkg::MidPoint)
                                         - int'(lane_scaled[stfp_pkg::ChPitch]);
            lane_trim[stfp_pkg::ChYaw] = int'(stfp_pkg::MidPoint)
                                       - int'(lane_scaled[stfp_pkg::ChYaw]);
            lane_trim[stfp_pkg::ChThr] = -int'(lane_scaled[stfp_pkg::ChThr]);
          end
          default: ;
        endcase
      end
      stfp_pkg::KindSend: begin
        for (int i = 0; i < 3; i++) fb[i] = head_bytes[i];
        for (int i = 0; i < Lanes; i++) begin
          fb[3 + 2 * i] = {6'd0, lane_trimmed[i][ChanW-1:8]};
          fb[4 + 2 * i] = lane_trimmed[i][7:0];
        end
        fb[11] = {7'd0, hold_on};
        fb[12] = {7'd0, off_on};
        sum = 0;
        for (int i = 0; i < SumSpan; i++) sum += fb[i];
        fb[13] = sum[31:24];
        fb[14] = sum[23:16];
        fb[15] = sum[15:8];
        fb[16] = sum[7:0];
        for (int i = 0; i < FrameLength; i++) begin
          b.data = fb[i];
          b.last = (i == FrameLength - 1);
          b.status = stfp_pkg::LinkOk;
          pending_beats.push_back(b);
        end
      end
      default: begin
        b.data = '0;
        b.last = 1'b0;
        case (r.outcome)
          stfp_pkg::OutMaxRetry: b.status = stfp_pkg::LinkErr;
          stfp_pkg::OutDelivered: begin
            b.status = stfp_pkg::LinkOk;
            hold_on = 1'b0;
            off_on = 1'b0;
          end
          default: b.status = stfp_pkg::LinkNone;
        endcase
        pending_beats.push_back(b);
      end
    endcase
  endfunction

  function automatic void queue_req(stfp_pkg::kind_t k, logic [Lanes-1:0][RawW-1:0] raws,
                                    stfp_pkg::key_t key, stfp_pkg::outcome_t oc);
    stick_req_t r;
    r.kind = k;
    r.raw = raws;
    r.key = key;
    r.outcome = oc;
    stick_reqs.push_back(r);
    queued_count++;
  endfunction

  function automatic logic [RawW-1:0] rand_raw();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return stfp_pkg::AdcFull;
      default: return RawW'($urandom);
    endcase
  endfunction

  function automatic logic [Lanes-1:0][RawW-1:0] rand_lanes();
    logic [Lanes-1:0][RawW-1:0] v;
    for (int i = 0; i < Lanes; i++) v[i] = rand_raw();
    return v;
  endfunction

  // returns 1 when the request does something
  function automatic bit queue_random();
    int unsigned pick;
    stfp_pkg::key_t key;
    pick = $urandom_range(0, 99);
    key = ($urandom_range(0, 9) < 7)
        ? stfp_pkg::key_t'($urandom_range(stfp_pkg::KeyUp, stfp_pkg::KeyRightxLong))
        : stfp_pkg::key_t'($urandom);
    if (pick < 35) begin
      queue_req(stfp_pkg::KindSample, rand_lanes(), stfp_pkg::key_t'($urandom),
                stfp_pkg::outcome_t'($urandom));
    end else if (pick < 65) begin
      queue_req(stfp_pkg::KindKey, rand_lanes(), key, stfp_pkg::outcome_t'($urandom));
    end else if (pick < 85) begin
      queue_req(stfp_pkg::KindSend, rand_lanes(), stfp_pkg::key_t'($urandom),
                stfp_pkg::outcome_t'($urandom));
    end else begin
      queue_req(stfp_pkg::KindReport, rand_lanes(), stfp_pkg::key_t'($urandom),
                stfp_pkg::outcome_t'($urandom));
    end
    if (pick >= 35 && pick < 65)
      return !(key == KeyNone || key == KeyLeftxLong || key >= KeyFirstSpare);
    return 1'b1;
  endfunction

  task automatic write_reg(stfp_pkg::reg_idx_t idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx <= stfp_pkg::RegHeadThree) head_bytes[idx] = val;
  endtask

  task automatic drain();
    while (accepted_count != queued_count || pending_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // sender: bursts of requests with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_beats(drv_req);
        accepted_count++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0 || stick_reqs.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else begin
          drv_req = stick_reqs.pop_front();
          s_axis_tdata_i <= {2'b00, drv_req.outcome, drv_req.key, drv_req.raw};
          s_axis_tuser_i <= drv_req.kind;
          s_axis_tvalid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // receiver: stall pattern is redrawn each time the low eight bits of the cycle count wrap to zero
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
    if (cycle_count[7:0] == 8'd0) stall_mode <= stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      StallNone: m_axis_tready_i <= 1'b1;
      StallCoin: m_axis_tready_i <= 1'($urandom_range(0, 1));
      StallPeriodic: m_axis_tready_i <= (cycle_count[1:0] != 2'b11);
      default: m_axis_tready_i <= (cycle_count[4:0] >= 5'd14);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat data %h last %b status %0d", $realtime,
                 m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        fail_count++;
      end else begin
        got_beat = pending_beats.pop_front();
        if (m_axis_tdata_o !== got_beat.data) begin
          $display("%0t: frame byte expected %h actual %h", $realtime, got_beat.data,
                   m_axis_tdata_o);
          fail_count++;
        end
        if (m_axis_tlast_o !== got_beat.last) begin
          $display("%0t: last expected %b actual %b", $realtime, got_beat.last, m_axis_tlast_o);
          fail_count++;
        end
        if (m_axis_tuser_o !== got_beat.status) begin
          $display("%0t: link status expected %0d actual %0d", $realtime, got_beat.status,
                   m_axis_tuser_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned done;
    logic [7:0] heads[3];
    logic [Lanes-1:0][RawW-1:0] mid_raw;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < 3; i++) begin
        case (phase)
          1: heads[i] = 8'hFF;
          2: heads[i] = 8'h00;
          default: heads[i] = 8'($urandom);
        endcase
      end
      write_reg(stfp_pkg::RegHeadOne, heads[0]);
      write_reg(stfp_pkg::RegHeadTwo, heads[1]);
      write_reg(stfp_pkg::RegHeadThree, heads[2]);
      write_reg(RegUnused, 8'($urandom));
      if (phase == 0) begin
        // full deflection both ways
        queue_req(stfp_pkg::KindSample, '0, KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSend, '0, KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSample, {Lanes{stfp_pkg::AdcFull}}, KeyNone,
                  stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSend, '1, KeyLastSpare, OutQuietAlt);
        // trim keys, flag keys and the no-op codes
        queue_req(stfp_pkg::KindKey, '0, stfp_pkg::KeyUp, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, stfp_pkg::KeyRight, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, KeyLeftxLong, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, KeyLastSpare, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, KeyFirstSpare, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, stfp_pkg::KeyLeftx, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, stfp_pkg::KeyRightx, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSample, rand_lanes(), KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, stfp_pkg::KeyDown, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, stfp_pkg::KeyLeft, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSend, '0, KeyNone, stfp_pkg::OutMaxRetry);
        // reports: no status, error, then delivery clears the flags
        queue_req(stfp_pkg::KindReport, '0, KeyNone, OutQuiet);
        queue_req(stfp_pkg::KindReport, '0, KeyNone, OutQuietAlt);
        queue_req(stfp_pkg::KindReport, '0, KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSend, '0, KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindReport, '0, KeyNone, stfp_pkg::OutDelivered);
        // recentre keeps trimmed values until the next sample
        for (int i = 0; i < Lanes; i++) mid_raw[i] = rand_raw();
        queue_req(stfp_pkg::KindSample, mid_raw, KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, stfp_pkg::KeyRightxLong, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSend, '0, KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSample, mid_raw, KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSend, '0, KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSample, rand_lanes(), KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSend, '0, KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindKey, '0, stfp_pkg::KeyRightxLong, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSample, rand_lanes(), KeyNone, stfp_pkg::OutMaxRetry);
        queue_req(stfp_pkg::KindSend, '0, KeyNone, stfp_pkg::OutMaxRetry);
      end
      done = 0;
      while (done < RandomRequests / 4) done += queue_random();
      drain();
    end
    if (pending_beats.size() != 0) begin
      $display("%0t: %0d frame beats never arrived", $realtime, pending_beats.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
